// ===== rtl/kufe_pkg.sv =====
// Shared types and constants for the union-find engine.
// Holds the item structs, controller states and datapath operation codes.
// No dependencies.
package kufe_pkg;

  localparam int MAX_NODES      = 1024;
  localparam int NODE_W         = 10;
  localparam int NCNT_W         = 11;
  localparam int WEIGHT_W       = 32;
  localparam int SUM_W          = 48;
  localparam int CNT_W          = 10;
  localparam int RANK_W         = 4;
  localparam int APB_AW         = 2;
  localparam int APB_DW         = 32;
  localparam int NODE_COUNT_RST = 1024;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(15);

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic {
    OPC_CLEAR = 1'b0,
    OPC_EDGE  = 1'b1
  } kufe_opcode_t;

  typedef struct packed {
    logic                       opcode;
    logic [NODE_W-1:0]          node_a;
    logic [NODE_W-1:0]          node_b;
    logic signed [WEIGHT_W-1:0] weight;
  } kufe_in_t;

  typedef struct packed {
    logic                    accepted;
    logic                    range_error;
    logic signed [SUM_W-1:0] total_weight;
    logic [CNT_W-1:0]        chosen_count;
  } kufe_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_COMP,
    ST_RANK,
    ST_LINK
  } kufe_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SWEEP,
    OP_ACCEPT,
    OP_WALK,
    OP_COMP,
    OP_RANK_A,
    OP_RANK_B,
    OP_LINK,
    OP_REPORT
  } kufe_op_t;

  typedef struct packed {
    logic edge_op;
    logic in_range;
    logic sweep_done;
    logic walk_done;
    logic comp_done;
    logic side_b;
    logic roots_equal;
  } kufe_status_t;

endpackage

// ===== rtl/kufe_ctrl.sv =====
// Controller state machine of the union-find engine.
// Sequences clear sweeps, root walks, path compression and linking.
// Depends on kufe_pkg.
module kufe_ctrl
  import kufe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  kufe_status_t sts,
  output logic         busy,
  output kufe_op_t     op
);

  kufe_state_t state_r;
  kufe_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_INIT: begin
        op = OP_SWEEP;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op = OP_ACCEPT;
          if (!sts.edge_op) begin
            state_nxt = ST_CLEAR;
          end else if (sts.in_range) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_CLEAR: begin
        if (sts.sweep_done) begin
          op        = OP_REPORT;
          state_nxt = ST_IDLE;
        end else begin
          op = OP_SWEEP;
        end
      end
      ST_WALK: begin
        op = OP_WALK;
        if (sts.walk_done) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!sts.comp_done) begin
          op = OP_COMP;
        end else if (!sts.side_b) begin
          // first endpoint settled: move on to the second
          op        = OP_COMP;
          state_nxt = ST_WALK;
        end else if (sts.roots_equal) begin
          op        = OP_REPORT;
          state_nxt = ST_IDLE;
        end else begin
          op        = OP_RANK_A;
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        op        = OP_RANK_B;
        state_nxt = ST_LINK;
      end
      ST_LINK: begin
        op        = OP_LINK;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/kufe_dpath.sv =====
// Datapath of the union-find engine: parent and rank memories, walk
// registers, running totals, node_count register and the result register.
// Depends on kufe_pkg.
module kufe_dpath
  import kufe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  kufe_op_t          op,
  input  kufe_in_t          in_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output kufe_status_t      sts,
  output logic              out_valid,
  output kufe_out_t         out_data
);

  logic [NODE_W-1:0] parent_mem [MAX_NODES];
  logic [RANK_W-1:0] rank_mem   [MAX_NODES];

  logic [NCNT_W-1:0]   node_count_r;
  logic [NCNT_W-1:0]   sweep_r;
  logic [NCNT_W-1:0]   sweep_end_r;
  logic [NCNT_W-1:0]   n_eff;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic                out_acc_r;
  logic                out_err_r;

  node_t               a_r;
  node_t               b_r;
  logic signed [WEIGHT_W-1:0] w_r;
  node_t               root_r;
  node_t               cur_r;
  node_t               ra_r;
  logic                side_r;
  logic [RANK_W-1:0]   rank_a_r;

  node_t               p_rdata_r;
  logic [RANK_W-1:0]   r_rdata_r;

  node_t               p_raddr;
  logic                p_we;
  node_t               p_waddr;
  node_t               p_wdata;
  node_t               r_raddr;
  logic                r_we;
  node_t               r_waddr;
  logic [RANK_W-1:0]   r_wdata;

  logic cfg_we;
  logic edge_op;
  logic in_range;
  logic sweep_done;
  logic walk_done;
  logic comp_done;
  logic a_lower;

  assign cfg_we  = psel & penable & pwrite;
  assign prdata  = APB_DW'(node_count_r);

  assign n_eff = (node_count_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_r;

  assign edge_op    = (in_data.opcode == OPC_EDGE);
  assign in_range   = (NCNT_W'(in_data.node_a) < n_eff) && (NCNT_W'(in_data.node_b) < n_eff);
  assign sweep_done = (sweep_r == sweep_end_r);
  assign walk_done  = (p_rdata_r == root_r);
  assign comp_done  = (cur_r == root_r);
  assign a_lower    = (rank_a_r < r_rdata_r);

  always_comb begin
    sts.edge_op     = edge_op;
    sts.in_range    = in_range;
    sts.sweep_done  = sweep_done;
    sts.walk_done   = walk_done;
    sts.comp_done   = comp_done;
    sts.side_b      = side_r;
    sts.roots_equal = (ra_r == root_r);
  end

  // memory port selection
  always_comb begin
    p_raddr = root_r;
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_r;
    r_raddr = ra_r;
    r_we    = 1'b0;
    r_waddr = ra_r;
    r_wdata = '0;
    case (op)
      OP_SWEEP: begin
        p_we    = !sweep_done;
        p_waddr = sweep_r[NODE_W-1:0];
        p_wdata = sweep_r[NODE_W-1:0];
        r_we    = !sweep_done;
        r_waddr = sweep_r[NODE_W-1:0];
      end
      OP_ACCEPT: begin
        p_raddr = in_data.node_a;
      end
      OP_WALK: begin
        p_raddr = walk_done ? (side_r ? b_r : a_r) : p_rdata_r;
      end
      OP_COMP: begin
        if (!comp_done) begin
          p_we    = 1'b1;
          p_raddr = p_rdata_r;
        end else begin
          p_raddr = b_r;
        end
      end
      OP_RANK_A: begin
        r_raddr = ra_r;
      end
      OP_RANK_B: begin
        r_raddr = root_r;
      end
      OP_LINK: begin
        p_we = 1'b1;
        if (a_lower) begin
          p_waddr = ra_r;
          p_wdata = root_r;
        end else begin
          p_waddr = root_r;
          p_wdata = ra_r;
          r_we    = (rank_a_r == r_rdata_r) && (rank_a_r < RANK_MAX);
          r_wdata = rank_a_r + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    r_rdata_r <= rank_mem[r_raddr];
  end

  // control state, totals and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_W'(NODE_COUNT_RST);
      sweep_r      <= '0;
      sweep_end_r  <= NCNT_W'(MAX_NODES);
      sum_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        node_count_r <= pwdata[NCNT_W-1:0];
      end
      case (op)
        OP_SWEEP: begin
          if (!sweep_done) begin
            sweep_r <= sweep_r + NCNT_W'(1);
          end
        end
        OP_ACCEPT: begin
          if (!edge_op) begin
            sweep_r     <= '0;
            sweep_end_r <= n_eff;
            sum_r       <= '0;
            cnt_r       <= '0;
          end else if (!in_range) begin
            out_valid_r <= 1'b1;
          end
        end
        OP_LINK: begin
          sum_r       <= sum_r + SUM_W'(w_r);
          cnt_r       <= cnt_r + CNT_W'(1);
          out_valid_r <= 1'b1;
        end
        OP_REPORT: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // walk registers and result flags
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        a_r       <= in_data.node_a;
        b_r       <= in_data.node_b;
        w_r       <= in_data.weight;
        root_r    <= in_data.node_a;
        side_r    <= 1'b0;
        out_acc_r <= 1'b0;
        out_err_r <= edge_op & !in_range;
      end
      OP_WALK: begin
        if (walk_done) begin
          cur_r <= side_r ? b_r : a_r;
        end else begin
          root_r <= p_rdata_r;
        end
      end
      OP_COMP: begin
        if (!comp_done) begin
          cur_r <= p_rdata_r;
        end else begin
          ra_r   <= root_r;
          side_r <= 1'b1;
          root_r <= b_r;
        end
      end
      OP_RANK_B: begin
        rank_a_r <= r_rdata_r;
      end
      OP_LINK: begin
        out_acc_r <= 1'b1;
        out_err_r <= 1'b0;
      end
      OP_REPORT: begin
        out_acc_r <= 1'b0;
        out_err_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_data.accepted     = out_acc_r;
  assign out_data.range_error  = out_err_r;
  assign out_data.total_weight = sum_r;
  assign out_data.chosen_count = cnt_r;

endmodule

// ===== rtl/kruskal_union_find_engine.sv =====
// Edge acceptance for minimum spanning trees: one disjoint-set item at a time.
// Out-of-range edge: reported with no walk; clear: sweeps n entries
// (n = effective count); edge: walk and compress each chain, then link unless the roots match.
// Throughput: one item at a time; busy drops in the cycle the result shows, so the
// next item can be taken at the edge that takes the result.
// Reset: synchronous active-low; a clearing pass over all MAX_NODES entries rebuilds
// the tables with busy high. The result strobe cannot be stalled.
module kruskal_union_find_engine
  import kufe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              start,
  output logic              busy,
  input  kufe_in_t          in_data,
  // result channel: one-cycle strobe
  output logic              out_valid,
  output kufe_out_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  kufe_op_t     op;
  kufe_status_t sts;
  logic [APB_DW-1:0] node_count_rd;

  // The controller walks one parent chain at a time: each step reads the
  // parent memory and compares against the current candidate root, then a
  // second pass rewrites every node on the chain to point at the root.
  kufe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .op    (op)
  );

  // The datapath owns both tables, the totals and node_count.
  kufe_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pwdata    (pwdata),
    .prdata    (node_count_rd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Only one register exists, so every address decodes to node_count.
  assign prdata = (paddr == '0) ? node_count_rd : node_count_rd;
  assign pready = 1'b1;

endmodule

// ===== rtl/kufe_checker.sv =====
// Port-level checks for the union-find engine, bound to the top level.
// Depends on kufe_pkg.
module kufe_checker
  import kufe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input kufe_out_t out_data,
  input logic      pready
);

  // the clearing pass holds off items right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) $past(!rst_n) |-> busy)
    else $error("busy low right after reset");

  a_flags_exclusive: assert property (@(posedge clk)
    disable iff (!rst_n) out_valid |-> !(out_data.accepted && out_data.range_error))
    else $error("accepted and range_error both set");

  a_error_timing: assert property (@(posedge clk)
    disable iff (!rst_n) (out_valid && out_data.range_error) |-> $past(start && !busy))
    else $error("range error result not one cycle after its item");

  a_count_nonzero: assert property (@(posedge clk)
    disable iff (!rst_n) (out_valid && out_data.accepted) |-> (out_data.chosen_count != '0))
    else $error("accepted edge with zero count");

  a_pready: assert property (@(posedge clk)
    disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind kruskal_union_find_engine kufe_checker u_kufe_checker (.*);
